>>> src/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared sizes, operation codes and configuration register indices of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

	localparam int NUM_LEVELS = 4;
	localparam int MAX_TASKS  = 16;
	localparam int LVL_W      = $clog2(NUM_LEVELS);
	localparam int TID_W      = $clog2(MAX_TASKS);
	localparam int LEN_W      = $clog2(MAX_TASKS + 1);
	localparam int SLOTS      = NUM_LEVELS * MAX_TASKS;
	localparam int QW         = 16;
	localparam int TW         = 32;

	localparam logic [2:0] OP_ADD     = 3'd0;
	localparam logic [2:0] OP_CHOOSE  = 3'd1;
	localparam logic [2:0] OP_NEXT_Q  = 3'd2;
	localparam logic [2:0] OP_PREPARE = 3'd3;
	localparam logic [2:0] OP_DELETE  = 3'd4;
	localparam logic [2:0] OP_BOOST   = 3'd5;

	localparam logic [2:0] REG_Q0     = 3'd0;
	localparam logic [2:0] REG_Q1     = 3'd1;
	localparam logic [2:0] REG_Q2     = 3'd2;
	localparam logic [2:0] REG_Q3     = 3'd3;
	localparam logic [2:0] REG_BOOST  = 3'd4;

endpackage

>>> src/mlfq_ram.sv
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlfq_ram #(
	parameter int W = 4,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/mlfq_rem.sv
// ----------------------------------------------------------------------------
// mlfq_rem
// Bit-serial remainder of a 32-bit time by a 16-bit period, one bit a cycle.
// ----------------------------------------------------------------------------
module mlfq_rem import mlfq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [TW-1:0] dividend,
	input  logic [QW-1:0] divisor,
	output logic          done,
	output logic          rem_zero
);

	logic [QW-1:0] rem_q;
	logic [TW-1:0] dvd_q;
	logic [5:0]    cnt_q;
	logic          run_q;
	logic          done_q;
	logic [QW:0]   trial;
	logic [QW:0]   diff;

	assign trial = {rem_q, dvd_q[TW-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(TW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (run_q) begin
			dvd_q <= {dvd_q[TW-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[QW-1:0];
			end else begin
				rem_q <= trial[QW-1:0];
			end
		end
	end

	assign done     = done_q;
	assign rem_zero = (rem_q == '0);

endmodule

>>> src/mlfq_task_scheduler.sv
// ----------------------------------------------------------------------------
// mlfq_task_scheduler
// Four-level feedback queue scheduler with a sequencer over a slot RAM.
// ----------------------------------------------------------------------------
// Use: raise start with op and its operands while busy is low; the transaction
// is taken at that edge. Exactly one result follows, marked by a one-cycle
// done strobe with success, chosen_task, quantum_out and refused; the receiver
// cannot stall it and must take it in that cycle.
// Steps: add, next_quantum, unused codes and a prepare_switch that does not
// exhaust the slice answer in the cycle after they are taken. choose reads
// and checks each slot level by level from level 0 (the queues hold 16
// tasks in all). delete and an exhausting prepare_switch scan one level and
// shift the tail down, a read and a write per slot. boost runs the serial
// remainder unit, then moves the tasks of levels 1 to 3 to the tail of
// level 0. The slot RAM read port is registered, so each slot is read in
// one state and used in the next.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register at
// once; the user must write only while idle, the block does not enforce it.
// Reset: queues empty, no task present, start stamps zero, quanta 10, 20, 30,
// 40 and boost period 1000. Slot contents need no clearing.
// ----------------------------------------------------------------------------
module mlfq_task_scheduler import mlfq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [2:0]       op,
	input  logic [TID_W-1:0] task_id,
	input  logic [LVL_W-1:0] level,
	input  logic [TW-1:0]    now_ms,
	input  logic [15:0]      runnable_mask,
	input  logic [15:0]      executing_mask,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [QW-1:0]    cfg_wdata,
	output logic             done,
	output logic             success,
	output logic [TID_W-1:0] chosen_task,
	output logic [QW-1:0]    quantum_out,
	output logic             refused
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DIV      = 4'd1;
	localparam logic [3:0] S_SCAN_RD  = 4'd2;
	localparam logic [3:0] S_SCAN_CHK = 4'd3;
	localparam logic [3:0] S_FIND_RD  = 4'd4;
	localparam logic [3:0] S_FIND_CHK = 4'd5;
	localparam logic [3:0] S_SHIFT_RD = 4'd6;
	localparam logic [3:0] S_SHIFT_WR = 4'd7;
	localparam logic [3:0] S_POST     = 4'd8;
	localparam logic [3:0] S_BST_RD   = 4'd9;
	localparam logic [3:0] S_BST_CHK  = 4'd10;

	localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(NUM_LEVELS - 1);

	logic [3:0]       state_q;
	logic [QW-1:0]    quant_q [NUM_LEVELS];
	logic [QW-1:0]    bperiod_q;
	logic [LEN_W-1:0] len_q [NUM_LEVELS];
	logic             present_q [MAX_TASKS];
	logic [LVL_W-1:0] tlevel_q [MAX_TASKS];
	logic [QW-1:0]    ttl_q [MAX_TASKS];
	logic [TW-1:0]    stamp_q [MAX_TASKS];

	logic [2:0]       op_q;
	logic [TID_W-1:0] id_q;
	logic [LVL_W-1:0] lvl_q;
	logic [LVL_W-1:0] dst_q;
	logic [LEN_W-1:0] idx_q;
	logic [TW-1:0]    now_q;
	logic [15:0]      run_mask_q;
	logic [15:0]      exe_mask_q;

	logic             done_q;
	logic             success_q;
	logic [TID_W-1:0] chosen_q;
	logic [QW-1:0]    quantum_q;
	logic             refused_q;

	logic                     ram_we;
	logic [$clog2(SLOTS)-1:0] ram_waddr;
	logic [TID_W-1:0]         ram_wdata;
	logic [$clog2(SLOTS)-1:0] ram_raddr;
	logic [TID_W-1:0]         ram_rdata;

	logic          div_go;
	logic          div_done;
	logic          div_zero;

	logic          accept;
	logic          known;
	logic [TW-1:0] run_time;
	logic          exhausted;
	logic [LVL_W-1:0] cur_lvl;
	logic [LEN_W-1:0] idx_inc;

	assign accept    = start && (state_q == S_IDLE);
	assign known     = present_q[task_id];
	assign cur_lvl   = tlevel_q[task_id];
	assign run_time  = now_ms - stamp_q[task_id];
	assign exhausted = run_time >= {16'd0, ttl_q[task_id]};
	assign idx_inc   = idx_q + LEN_W'(1);
	assign div_go    = accept && (op == OP_BOOST);

	mlfq_ram #(.W(TID_W), .D(SLOTS)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mlfq_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (now_ms),
		.divisor  (bperiod_q),
		.done     (div_done),
		.rem_zero (div_zero)
	);

	// slot RAM port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = {lvl_q, idx_q[TID_W-1:0]};
		case (state_q)
			S_IDLE: begin
				if (accept && op == OP_ADD && !known && len_q[level] < LEN_W'(MAX_TASKS)) begin
					ram_we    = 1'b1;
					ram_waddr = {level, len_q[level][TID_W-1:0]};
					ram_wdata = task_id;
				end
			end
			S_SHIFT_RD: begin
				ram_raddr = {lvl_q, idx_inc[TID_W-1:0]};
			end
			S_SHIFT_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {lvl_q, idx_q[TID_W-1:0]};
				ram_wdata = ram_rdata;
			end
			S_POST: begin
				if (op_q == OP_PREPARE && len_q[dst_q] < LEN_W'(MAX_TASKS)) begin
					ram_we    = 1'b1;
					ram_waddr = {dst_q, len_q[dst_q][TID_W-1:0]};
					ram_wdata = id_q;
				end
			end
			S_BST_CHK: begin
				if (len_q[0] < LEN_W'(MAX_TASKS)) begin
					ram_we    = 1'b1;
					ram_waddr = {LVL_W'(0), len_q[0][TID_W-1:0]};
					ram_wdata = ram_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			quant_q[0] <= 16'd10;
			quant_q[1] <= 16'd20;
			quant_q[2] <= 16'd30;
			quant_q[3] <= 16'd40;
			bperiod_q <= 16'd1000;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				len_q[i] <= '0;
			end
			for (int i = 0; i < MAX_TASKS; i++) begin
				present_q[i] <= 1'b0;
				stamp_q[i]   <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_Q0:    quant_q[0] <= cfg_wdata;
					REG_Q1:    quant_q[1] <= cfg_wdata;
					REG_Q2:    quant_q[2] <= cfg_wdata;
					REG_Q3:    quant_q[3] <= cfg_wdata;
					REG_BOOST: bperiod_q  <= cfg_wdata;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op)
							OP_ADD: begin
								done_q <= 1'b1;
								if (!known && len_q[level] < LEN_W'(MAX_TASKS)) begin
									len_q[level]       <= len_q[level] + LEN_W'(1);
									present_q[task_id] <= 1'b1;
								end
							end
							OP_CHOOSE: state_q <= S_SCAN_RD;
							OP_NEXT_Q: begin
								done_q <= 1'b1;
								if (known) begin
									stamp_q[task_id] <= now_ms;
								end
							end
							OP_PREPARE: begin
								if (known && exhausted) begin
									state_q <= S_FIND_RD;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_DELETE: begin
								if (known) begin
									state_q <= S_FIND_RD;
								end else begin
									done_q <= 1'b1;
								end
							end
							OP_BOOST: state_q <= S_DIV;
							default: done_q <= 1'b1;
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (div_zero && bperiod_q != '0) begin
							state_q <= S_BST_RD;
						end else begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				S_SCAN_RD: begin
					if (idx_q >= len_q[lvl_q]) begin
						if (lvl_q == LAST_LVL) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (run_mask_q[ram_rdata] && !exe_mask_q[ram_rdata]) begin
						stamp_q[ram_rdata] <= now_q;
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_FIND_RD: begin
					if (idx_q >= len_q[lvl_q]) begin
						state_q <= S_POST;
					end else begin
						state_q <= S_FIND_CHK;
					end
				end
				S_FIND_CHK: begin
					state_q <= (ram_rdata == id_q) ? S_SHIFT_RD : S_FIND_RD;
				end
				S_SHIFT_RD: begin
					if (idx_inc < len_q[lvl_q]) begin
						state_q <= S_SHIFT_WR;
					end else begin
						len_q[lvl_q] <= len_q[lvl_q] - LEN_W'(1);
						state_q <= S_POST;
					end
				end
				S_SHIFT_WR: state_q <= S_SHIFT_RD;
				S_POST: begin
					if (op_q == OP_PREPARE) begin
						if (len_q[dst_q] < LEN_W'(MAX_TASKS)) begin
							len_q[dst_q] <= len_q[dst_q] + LEN_W'(1);
						end
					end else begin
						present_q[id_q] <= 1'b0;
					end
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				S_BST_RD: begin
					if (idx_q >= len_q[lvl_q]) begin
						len_q[lvl_q] <= '0;
						if (lvl_q == LAST_LVL) begin
							state_q <= S_IDLE;
							done_q  <= 1'b1;
						end
					end else begin
						state_q <= S_BST_CHK;
					end
				end
				S_BST_CHK: begin
					if (len_q[0] < LEN_W'(MAX_TASKS)) begin
						len_q[0] <= len_q[0] + LEN_W'(1);
					end
					state_q <= S_BST_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operands, walk pointers, per-task payload and result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q       <= op;
					id_q       <= task_id;
					now_q      <= now_ms;
					run_mask_q <= runnable_mask;
					exe_mask_q <= executing_mask;
					idx_q      <= '0;
					lvl_q      <= (op == OP_BOOST) ? LVL_W'(1) :
					              (op == OP_CHOOSE) ? LVL_W'(0) : cur_lvl;
					dst_q      <= (cur_lvl == LAST_LVL) ? LAST_LVL : cur_lvl + LVL_W'(1);
					success_q  <= 1'b0;
					chosen_q   <= '0;
					quantum_q  <= '0;
					refused_q  <= 1'b0;
					case (op)
						OP_ADD: begin
							if (known || len_q[level] >= LEN_W'(MAX_TASKS)) begin
								refused_q <= 1'b1;
							end else begin
								success_q         <= 1'b1;
								tlevel_q[task_id] <= level;
								ttl_q[task_id]    <= quant_q[level];
							end
						end
						OP_NEXT_Q: begin
							if (known) begin
								success_q <= 1'b1;
								quantum_q <= ttl_q[task_id];
							end
						end
						OP_PREPARE: begin
							if (known && !exhausted) begin
								success_q      <= 1'b1;
								ttl_q[task_id] <= ttl_q[task_id] - run_time[QW-1:0];
								quantum_q      <= ttl_q[task_id] - run_time[QW-1:0];
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DIV: begin
				if (div_done && div_zero && bperiod_q != '0) begin
					success_q <= 1'b1;
				end
			end
			S_SCAN_RD: begin
				if (idx_q >= len_q[lvl_q] && lvl_q != LAST_LVL) begin
					lvl_q <= lvl_q + LVL_W'(1);
					idx_q <= '0;
				end
			end
			S_SCAN_CHK: begin
				if (run_mask_q[ram_rdata] && !exe_mask_q[ram_rdata]) begin
					success_q <= 1'b1;
					chosen_q  <= ram_rdata;
					quantum_q <= ttl_q[ram_rdata];
				end else begin
					idx_q <= idx_inc;
				end
			end
			S_FIND_CHK: begin
				if (ram_rdata != id_q) begin
					idx_q <= idx_inc;
				end
			end
			S_SHIFT_WR: idx_q <= idx_inc;
			S_POST: begin
				success_q <= 1'b1;
				if (op_q == OP_PREPARE) begin
					// a task that does not fit in the full destination level is still charged the new slice
					if (len_q[dst_q] < LEN_W'(MAX_TASKS)) begin
						tlevel_q[id_q] <= dst_q;
					end
					ttl_q[id_q] <= quant_q[dst_q];
					quantum_q   <= quant_q[dst_q];
				end
			end
			S_BST_RD: begin
				if (idx_q >= len_q[lvl_q] && lvl_q != LAST_LVL) begin
					lvl_q <= lvl_q + LVL_W'(1);
					idx_q <= '0;
				end
			end
			S_BST_CHK: begin
				if (len_q[0] < LEN_W'(MAX_TASKS)) begin
					tlevel_q[ram_rdata] <= '0;
				end
				ttl_q[ram_rdata] <= quant_q[0];
				idx_q <= idx_inc;
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign success     = success_q;
	assign chosen_task = chosen_q;
	assign quantum_out = quantum_q;
	assign refused     = refused_q;

endmodule

>>> sim/tb_mlfq_task_scheduler.sv
// ----------------------------------------------------------------------------
// tb_mlfq_task_scheduler
// Self-checking bench for the feedback queue scheduler: directed and random
// scheduling sequences, a cycle-free model of the queues predicts each result.
// ----------------------------------------------------------------------------
module tb_mlfq_task_scheduler;
	import mlfq_pkg::*;

	typedef struct packed {
		logic [2:0]       op;
		logic [TID_W-1:0] tid;
		logic [LVL_W-1:0] lvl;
		logic [TW-1:0]    now;
		logic [15:0]      run_m;
		logic [15:0]      exe_m;
	} sched_cmd_t;

	typedef struct packed {
		logic             ok;
		logic [TID_W-1:0] pick;
		logic [QW-1:0]    slice;
		logic             rej;
	} sched_resp_t;

	logic clk, arst_n;
	logic start, busy;
	logic [2:0] op;
	logic [TID_W-1:0] task_id;
	logic [LVL_W-1:0] level;
	logic [TW-1:0] now_ms;
	logic [15:0] runnable_mask, executing_mask;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [QW-1:0] cfg_wdata;
	logic done, success, refused;
	logic [TID_W-1:0] chosen_task;
	logic [QW-1:0] quantum_out;

	mlfq_task_scheduler dut (.*);

	// scheduler image
	int unsigned lvq[NUM_LEVELS][$];
	logic [LVL_W-1:0] t_lvl[MAX_TASKS];
	bit t_here[MAX_TASKS];
	logic [QW-1:0] t_ttl[MAX_TASKS];
	logic [TW-1:0] t_stamp[MAX_TASKS];
	logic [QW-1:0] slice_reg[4];
	logic [QW-1:0] boost_per;

	sched_cmd_t  pending_cmds[$];
	sched_resp_t expected_resps[$];
	int errors, mismatches;
	bit drain_hold, no_gaps;
	int gap_left, stall_cnt;

	function automatic void move_to_tail(int unsigned l, int unsigned t);
		lvq[l].push_back(t);
		t_lvl[t] = LVL_W'(l);
	endfunction

	function automatic void drop_from(int unsigned l, int unsigned t);
		foreach (lvq[l][i])
			if (lvq[l][i] == t) begin
				lvq[l].delete(i);
				return;
			end
	endfunction

	function automatic sched_resp_t schedule_step(sched_cmd_t c);
		sched_resp_t r;
		int unsigned t, dst;
		logic [TW-1:0] ran;
		bit found;
		r = '0;
		found = 0;
		case (c.op)
			OP_ADD: begin
				if (t_here[c.tid] || lvq[c.lvl].size() >= MAX_TASKS) r.rej = 1;
				else begin
					move_to_tail(c.lvl, c.tid);
					t_here[c.tid] = 1;
					t_ttl[c.tid] = slice_reg[c.lvl];
					r.ok = 1;
				end
			end
			OP_CHOOSE: begin
				for (int l = 0; l < NUM_LEVELS && !found; l++)
					foreach (lvq[l][i]) begin
						t = lvq[l][i];
						if (c.run_m[t] && !c.exe_m[t]) begin
							r.pick = TID_W'(t);
							r.slice = t_ttl[t];
							t_stamp[t] = c.now;
							r.ok = 1;
							found = 1;
							break;
						end
					end
			end
			OP_NEXT_Q: if (t_here[c.tid]) begin
				r.slice = t_ttl[c.tid];
				t_stamp[c.tid] = c.now;
				r.ok = 1;
			end
			OP_PREPARE: if (t_here[c.tid]) begin
				ran = c.now - t_stamp[c.tid];
				if (ran >= t_ttl[c.tid]) begin
					dst = (t_lvl[c.tid] + 1 < NUM_LEVELS) ? t_lvl[c.tid] + 1 : NUM_LEVELS - 1;
					drop_from(t_lvl[c.tid], c.tid);
					move_to_tail(dst, c.tid);
					t_ttl[c.tid] = slice_reg[dst];
				end else t_ttl[c.tid] = t_ttl[c.tid] - ran[QW-1:0];
				r.slice = t_ttl[c.tid];
				r.ok = 1;
			end
			OP_DELETE: if (t_here[c.tid]) begin
				drop_from(t_lvl[c.tid], c.tid);
				t_here[c.tid] = 0;
				r.ok = 1;
			end
			OP_BOOST: if (boost_per != 0 && c.now % boost_per == 0) begin
				for (int l = 1; l < NUM_LEVELS; l++) begin
					foreach (lvq[l][i]) begin
						move_to_tail(0, lvq[l][i]);
						t_ttl[lvq[l][i]] = slice_reg[0];
					end
					lvq[l].delete();
				end
				r.ok = 1;
			end
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_resps.push_back(schedule_step(pending_cmds.pop_front()));
		end
		if (start && busy) ;
		else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			start <= 0;
		end else begin
			if (pending_cmds.size() > 0 && !drain_hold && arst_n) begin
				sched_cmd_t c;
				c = pending_cmds[0];
				start <= 1;
				{op, task_id, level, now_ms, runnable_mask, executing_mask} <= c;
				if (!no_gaps && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 8);
			end else start <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (done) begin
			sched_resp_t e;
			if (expected_resps.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected transaction");
			end else begin
				e = expected_resps.pop_front();
				if (e !== {success, chosen_task, quantum_out, refused}) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch exp ok=%0d pick=%0d q=%0d rej=%0d got %0d %0d %0d %0d",
							e.ok, e.pick, e.slice, e.rej,
							success, chosen_task, quantum_out, refused);
				end
			end
		end
		if (done || (start && !busy)) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt > 20000) begin
			$display("tb_mlfq_task_scheduler: FAIL");
			$finish;
		end
	end

	task automatic queue_cmd(logic [2:0] o, int tid, int lv, logic [TW-1:0] n,
			logic [15:0] rm, logic [15:0] em);
		sched_cmd_t c;
		c = '{o, TID_W'(tid), LVL_W'(lv), n, rm, em};
		pending_cmds.push_back(c);
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() || expected_resps.size() || start) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [QW-1:0] v);
		cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_BOOST) boost_per = v; else slice_reg[idx] = v;
	endtask

	task automatic random_phase(int n);
		logic [TW-1:0] tnow;
		logic [2:0] o;
		tnow = $urandom;
		repeat (n) begin
			tnow += $urandom_range(0, 60);
			case ($urandom_range(0, 15))
				0, 1, 2: o = OP_ADD;
				3, 4, 5: o = OP_CHOOSE;
				6, 7: o = OP_NEXT_Q;
				8, 9, 10: o = OP_PREPARE;
				11, 12: o = OP_DELETE;
				13: o = OP_BOOST;
				14: o = 3'($urandom_range(6, 7));
				default: o = 3'($urandom_range(0, 7));
			endcase
			if (o == OP_BOOST && $urandom_range(0, 1) && boost_per != 0)
				tnow = tnow - tnow % boost_per;
			queue_cmd(o, $urandom_range(0, 15), $urandom_range(0, 3),
				($urandom_range(0, 9) == 0) ? $urandom : tnow,
				16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		errors = 0; mismatches = 0; drain_hold = 0; no_gaps = 0;
		gap_left = 0; stall_cnt = 0;
		start = 0; op = OP_ADD; task_id = 0; level = 0; now_ms = 0;
		runnable_mask = 0; executing_mask = 0;
		cfg_we = 0; cfg_index = REG_Q0; cfg_wdata = 0;
		slice_reg = '{16'd10, 16'd20, 16'd30, 16'd40};
		boost_per = 16'd1000;
		for (int i = 0; i < MAX_TASKS; i++) begin
			t_here[i] = 0; t_stamp[i] = 0; t_ttl[i] = 0; t_lvl[i] = 0;
		end
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: fill, refuse, choose, exhaust, boost, delete, bad codes
		for (int i = 0; i < 16; i++) queue_cmd(OP_ADD, i, 3, 0, 0, 0);
		queue_cmd(OP_ADD, 5, 0, 0, 0, 0);
		queue_cmd(OP_CHOOSE, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 16'h0001);
		queue_cmd(OP_NEXT_Q, 15, 0, 32'd5, 0, 0);
		queue_cmd(OP_PREPARE, 15, 0, 32'd100, 0, 0);
		queue_cmd(OP_PREPARE, 1, 0, 32'd3, 0, 0);
		queue_cmd(OP_BOOST, 0, 0, 32'd1001, 0, 0);
		queue_cmd(OP_BOOST, 0, 0, 32'd0, 0, 0);
		queue_cmd(OP_DELETE, 2, 0, 0, 0, 0);
		queue_cmd(OP_DELETE, 2, 0, 0, 0, 0);
		queue_cmd(3'd6, 0, 0, 0, 16'hFFFF, 0);
		queue_cmd(3'd7, 15, 3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
		wait_idle();

		write_reg(REG_Q0, 16'd1); write_reg(REG_Q1, 16'd65535);
		write_reg(REG_Q2, 16'd7); write_reg(REG_Q3, 16'd1);
		write_reg(REG_BOOST, 16'd1);
		random_phase(300);
		// sender holds off until all results are back
		while (pending_cmds.size() > 150) @(posedge clk);
		drain_hold = 1;
		while (expected_resps.size() || start) @(posedge clk);
		drain_hold = 0;
		wait_idle();

		write_reg(REG_Q0, 16'd65535); write_reg(REG_Q1, 16'd25);
		write_reg(REG_Q2, 16'd1); write_reg(REG_Q3, 16'd65535);
		write_reg(REG_BOOST, 16'd65535);
		random_phase(400);
		wait_idle();

		write_reg(REG_Q0, 16'd10); write_reg(REG_Q1, 16'd20);
		write_reg(REG_Q2, 16'd30); write_reg(REG_Q3, 16'd40);
		write_reg(REG_BOOST, 16'd0);
		random_phase(200);
		wait_idle();
		write_reg(REG_BOOST, 16'd64);
		no_gaps = 1;
		random_phase(200);
		wait_idle();

		if (errors == 0) $display("tb_mlfq_task_scheduler: PASS");
		else $display("tb_mlfq_task_scheduler: FAIL");
		$finish;
	end
endmodule
